// ===== rtl/core/kt_pkg.sv =====
// kt_pkg: widths, step counts, register indexes and output limits for the
// karman-tsien pressure coefficient block; no dependencies
package kt_pkg;

	// field widths
	localparam int SPEED_W = 18;  // signed q3.14 surface speed
	localparam int QINF_W  = 17;  // unsigned q3.14 freestream speed
	localparam int MACH_W  = 16;  // unsigned q0.16 mach number
	localparam int CP_W    = 24;  // signed q7.16 pressure coefficient
	localparam int CFG_W   = 17;  // widest configuration register
	localparam int IDX_W   = 1;   // register index

	// internal widths
	localparam int ACC_W   = 52;  // serial multiplier accumulator and denominator
	localparam int MPL_W   = 18;  // serial multiplier operand
	localparam int BETA_W  = 17;  // beta in q1.16
	localparam int CF_W    = 15;  // correction factor, always below 2^15
	localparam int DIFF_W  = 35;  // |qinf^2 - q^2|
	localparam int QUO_W   = 24;  // divider quotient
	localparam int CNT_W   = 5;

	// step counts of the serial units
	localparam int MUL_STEPS  = MPL_W;
	localparam int SQRT_STEPS = 17;
	localparam int CF_STEPS   = CF_W;
	localparam int DIV_STEPS  = QUO_W;

	// register indexes
	localparam logic [IDX_W-1:0] REG_FREESTREAM_SPEED = 1'd0;
	localparam logic [IDX_W-1:0] REG_FREESTREAM_MACH  = 1'd1;

	localparam logic [QINF_W-1:0] QINF_RESET = 17'd16384;
	localparam logic [MACH_W-1:0] MACH_RESET = 16'd0;

	// saturation limits
	localparam logic [CP_W-1:0] CP_MAX = 24'h7FFFFF;
	localparam logic [CP_W-1:0] CP_MIN = 24'h800000;

endpackage

// ===== rtl/core/kt_stream_if.sv =====
// kt_sample_if and kt_result_if: valid/ready channels of the pressure
// coefficient block; depends on kt_pkg for the field widths
interface kt_sample_if import kt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] surface_speed;
	logic                      last_sample;

	modport source (output valid, surface_speed, last_sample, input ready);
	modport sink (input valid, surface_speed, last_sample, output ready);
endinterface

interface kt_result_if import kt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [CP_W-1:0] pressure_coeff;
	logic                   bad_denominator;
	logic                   run_invalid;
	logic                   last_result;

	modport source (output valid, pressure_coeff, bad_denominator, run_invalid, last_result,
		input ready);
	modport sink (input valid, pressure_coeff, bad_denominator, run_invalid, last_result,
		output ready);
endinterface

// ===== rtl/core/karman_tsien_pressure_coefficient.sv =====
// karman_tsien_pressure_coefficient: compressible pressure coefficient per speed sample
// depends on kt_pkg and on kt_sample_if / kt_result_if
// a sample runs through two 18-step serial multiplies and the 24-step restoring divider;
//   a bad denominator or a saturated quotient skips the divider, and the first sample
//   after reset also derives beta and the factor; one sample is in work at a time, the
//   next is taken once the result is written; a finished result waits in the output register
// reset: arst_n clears control, flags and configuration (speed 1.0, mach 0)
module karman_tsien_pressure_coefficient import kt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	kt_sample_if.sink         sample,
	kt_result_if.source       result
);

	// sequencer phases
	typedef enum logic [3:0] {
		IDLE,    // wait for a sample transfer
		M2,      // mach squared on multiplier x
		SQRT,    // beta = sqrt(1 - m^2), two radicand bits per step
		CF,      // factor = m^2/2 / (1 + beta), one quotient bit per step
		AB_LD,   // load qinf and |q| into both multipliers
		AB,      // qinf^2 on x, q^2 on y
		DIFF,    // sign and magnitude of qinf^2 - q^2, load the products
		PROD,    // beta*qinf^2 on x, factor*diff on y
		DEN,     // form denominator, decide bad
		DIVCHK,  // saturation check of the quotient
		DIV,     // restoring division, one bit per step
		FIN      // write result register
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic step_last;

	// configuration
	logic [QINF_W-1:0] qinf_q;
	logic [MACH_W-1:0] mach_q;

	// sample
	logic [SPEED_W-1:0] magq_q;
	logic [QINF_W-1:0]  qd_q;
	logic               last_q;

	// derived constants
	logic              derived_q;
	logic              sticky_q;
	logic [BETA_W-1:0] beta_q;
	logic [CF_W-1:0]   cf_q;

	// two shift-add multipliers
	logic [ACC_W-1:0] mcx_q, accx_q, accx_nx;
	logic [ACC_W-1:0] mcy_q, accy_q, accy_nx;
	logic [MPL_W-1:0] mplx_q, mply_q;

	// square root and factor division
	logic [33:0]       xs_q;
	logic [17:0]       sq_rem_q;
	logic [19:0]       sq_try;
	logic [18:0]       sq_trial;
	logic [16:0]       cf_rem_q;
	logic [CF_W-1:0]   cfn_q;
	logic [17:0]       cf_try, cf_den;

	// main division
	logic [DIFF_W-1:0] diff_q, diff_c;
	logic              neg_q, neg_c;
	logic [ACC_W-1:0]  d_q, d_c;
	logic              bad_q, bad_c;
	logic [ACC_W-1:0]  dv_rem_q;
	logic [ACC_W:0]    dv_try;
	logic [QUO_W-1:0]  quo_q;
	logic              big_q;

	logic [50:0] p1;
	logic [49:0] p2;
	logic [ACC_W-1:0] psum;

	logic               take_in, put_out, big;
	logic [CP_W-1:0]    cp_c;
	logic               sticky_nx;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qinf_q <= QINF_RESET;
			mach_q <= MACH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_FREESTREAM_SPEED: qinf_q <= wr_data[QINF_W-1:0];
				REG_FREESTREAM_MACH:  mach_q <= wr_data[MACH_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample.ready = (state_q == IDLE);
	assign take_in      = sample.valid && sample.ready;
	// the output register is free or drains in this cycle
	assign put_out      = (state_q == FIN) && (!result.valid || result.ready);

	always_comb begin
		case (state_q)
			M2, AB, PROD: step_last = (cnt_q == CNT_W'(MUL_STEPS - 1));
			SQRT:         step_last = (cnt_q == CNT_W'(SQRT_STEPS - 1));
			CF:           step_last = (cnt_q == CNT_W'(CF_STEPS - 1));
			DIV:          step_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
			default:      step_last = 1'b0;
		endcase
	end

	// one multiplier bit per cycle
	assign accx_nx = mplx_q[0] ? accx_q + mcx_q : accx_q;
	assign accy_nx = mply_q[0] ? accy_q + mcy_q : accy_q;

	// square root step: bring down two radicand bits, try root*4+1
	assign sq_try   = {sq_rem_q, xs_q[33:32]};
	assign sq_trial = {beta_q, 2'b01};

	// factor division step
	assign cf_den = 18'(1 << 16) + {1'b0, beta_q};
	assign cf_try = {cf_rem_q, cfn_q[CF_W-1]};

	// sign of qinf^2 - q^2 and its magnitude
	always_comb begin
		neg_c  = accy_q[DIFF_W-1:0] > {1'b0, accx_q[33:0]};
		diff_c = neg_c ? accy_q[DIFF_W-1:0] - {1'b0, accx_q[33:0]}
		               : {1'b0, accx_q[33:0]} - accy_q[DIFF_W-1:0];
	end

	// denominator beta*a +/- factor*|a-b|, exact sign
	assign p1   = accx_q[50:0];
	assign p2   = accy_q[49:0];
	assign psum = {1'b0, p1} + {2'b0, p2};
	always_comb begin
		if (!neg_q) begin
			d_c   = psum;
			bad_c = (psum == '0);
		end else begin
			bad_c = ({1'b0, p2} >= p1);
			d_c   = {1'b0, p1 - {1'b0, p2}};
		end
	end

	// remainder doubles each step, the low numerator bits are all zero
	assign dv_try = {dv_rem_q, 1'b0};

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				if (take_in) begin
					magq_q <= sample.surface_speed[SPEED_W-1]
						? ~sample.surface_speed + SPEED_W'(1) : sample.surface_speed;
					qd_q   <= (qinf_q == '0) ? QINF_W'(1) : qinf_q;
					last_q <= sample.last_sample;
					mcx_q  <= ACC_W'(mach_q);
					mplx_q <= MPL_W'(mach_q);
					accx_q <= '0;
				end
			end
			M2: begin
				accx_q <= accx_nx;
				mcx_q  <= {mcx_q[ACC_W-2:0], 1'b0};
				mplx_q <= mplx_q >> 1;
				if (step_last) begin
					// radicand 2^32 - m^2, top bit pad to an even count
					xs_q     <= {1'b0, 33'h1_0000_0000 - {1'b0, accx_nx[31:0]}};
					sq_rem_q <= '0;
					beta_q   <= '0;
				end
			end
			SQRT: begin
				xs_q <= {xs_q[31:0], 2'b00};
				if (sq_try >= {1'b0, sq_trial}) begin
					sq_rem_q <= 18'(sq_try - {1'b0, sq_trial});
					beta_q   <= {beta_q[BETA_W-2:0], 1'b1};
				end else begin
					sq_rem_q <= sq_try[17:0];
					beta_q   <= {beta_q[BETA_W-2:0], 1'b0};
				end
				if (step_last) begin
					// m^2/2: high 16 bits are below the divisor already
					cf_rem_q <= {1'b0, accx_q[31:16]};
					cfn_q    <= accx_q[15:1];
					cf_q     <= '0;
				end
			end
			CF: begin
				cfn_q <= {cfn_q[CF_W-2:0], 1'b0};
				if (cf_try >= cf_den) begin
					cf_rem_q <= 17'(cf_try - cf_den);
					cf_q     <= {cf_q[CF_W-2:0], 1'b1};
				end else begin
					cf_rem_q <= cf_try[16:0];
					cf_q     <= {cf_q[CF_W-2:0], 1'b0};
				end
			end
			AB_LD: begin
				mcx_q  <= ACC_W'(qd_q);
				mplx_q <= MPL_W'(qd_q);
				accx_q <= '0;
				mcy_q  <= ACC_W'(magq_q);
				mply_q <= magq_q;
				accy_q <= '0;
			end
			AB, PROD: begin
				accx_q <= accx_nx;
				mcx_q  <= {mcx_q[ACC_W-2:0], 1'b0};
				mplx_q <= mplx_q >> 1;
				accy_q <= accy_nx;
				mcy_q  <= {mcy_q[ACC_W-2:0], 1'b0};
				mply_q <= mply_q >> 1;
			end
			DIFF: begin
				neg_q  <= neg_c;
				diff_q <= diff_c;
				mcx_q  <= ACC_W'(accx_q[33:0]);
				mplx_q <= MPL_W'(beta_q);
				accx_q <= '0;
				mcy_q  <= ACC_W'(diff_c);
				mply_q <= MPL_W'(cf_q);
				accy_q <= '0;
			end
			DEN: begin
				d_q      <= d_c;
				bad_q    <= bad_c;
				dv_rem_q <= ACC_W'({diff_q, 8'b0});
			end
			DIVCHK: begin
				// diff*2^32 >= d*2^24 means the quotient exceeds 24 bits
				big_q <= (dv_rem_q >= d_q);
				quo_q <= '0;
			end
			DIV: begin
				if (dv_try >= {1'b0, d_q}) begin
					dv_rem_q <= ACC_W'(dv_try - {1'b0, d_q});
					quo_q    <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					dv_rem_q <= dv_try[ACC_W-1:0];
					quo_q    <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// saturate and apply the sign
	assign big = big_q || quo_q[QUO_W-1];
	always_comb begin
		if (bad_q)
			cp_c = CP_MIN;
		else if (neg_q)
			cp_c = big ? CP_MIN : CP_W'(~{1'b0, quo_q[QUO_W-2:0]} + CP_W'(1));
		else
			cp_c = big ? CP_MAX : quo_q;
	end

	assign sticky_nx = sticky_q || bad_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                <= IDLE;
			cnt_q                  <= '0;
			derived_q              <= 1'b0;
			sticky_q               <= 1'b0;
			result.valid           <= 1'b0;
			result.pressure_coeff  <= '0;
			result.bad_denominator <= 1'b0;
			result.run_invalid     <= 1'b0;
			result.last_result     <= 1'b0;
		end else begin
			// a new result loaded in the same cycle keeps valid high
			if (result.valid && result.ready && !put_out)
				result.valid <= 1'b0;
			if (step_last)
				cnt_q <= '0;
			else if (state_q == M2 || state_q == SQRT || state_q == CF || state_q == AB ||
				state_q == PROD || state_q == DIV)
				cnt_q <= cnt_q + CNT_W'(1);
			case (state_q)
				IDLE: begin
					if (take_in)
						state_q <= derived_q ? AB_LD : M2;
				end
				M2:    if (step_last) state_q <= SQRT;
				SQRT:  if (step_last) state_q <= CF;
				CF: begin
					if (step_last) begin
						derived_q <= 1'b1;
						state_q   <= AB_LD;
					end
				end
				AB_LD: state_q <= AB;
				AB:    if (step_last) state_q <= DIFF;
				DIFF:  state_q <= PROD;
				PROD:  if (step_last) state_q <= DEN;
				DEN:   state_q <= bad_c ? FIN : DIVCHK;
				DIVCHK: state_q <= (dv_rem_q >= d_q) ? FIN : DIV;
				DIV:   if (step_last) state_q <= FIN;
				FIN: begin
					if (put_out) begin
						result.valid           <= 1'b1;
						result.pressure_coeff  <= cp_c;
						result.bad_denominator <= bad_q;
						result.run_invalid     <= last_q && sticky_nx;
						result.last_result     <= last_q;
						// run flag is reported on the last sample, then cleared
						sticky_q               <= last_q ? 1'b0 : sticky_nx;
						state_q                <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// beta and factor are derived once per reset
	a_derived_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(derived_q))
		else $error("derived constants dropped after derivation");

	// a flagged item always carries the clamp value
	a_bad_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_denominator |-> result.pressure_coeff == CP_MIN)
		else $error("bad denominator without clamped coefficient");

	// run flag only on the closing item
	a_run_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.run_invalid |-> result.last_result)
		else $error("run flag reported before the last sample");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample taken while one is still in work");

endmodule

// ===== dv/karman_tsien_pressure_coefficient_checker.sv =====
// karman_tsien_pressure_coefficient_checker: watches the sample, result and register
// write ports, predicts each pressure coefficient and compares it in order
// depends on kt_pkg and on kt_sample_if / kt_result_if
module karman_tsien_pressure_coefficient_checker import kt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	kt_sample_if             sample,
	kt_result_if             result,
	output int               errors,
	output int               pending
);

	localparam int FRAC = 16;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [CP_W-1:0] pressure_coeff;
		logic                   bad_denominator;
		logic                   run_invalid;
		logic                   last_result;
	} cp_result_t;

	logic [QINF_W-1:0] qinf_reg;
	logic [MACH_W-1:0] mach_reg;
	logic [BETA_W-1:0] beta_q;
	logic [BETA_W-1:0] factor_q;
	logic              derived;
	logic              sticky_bad;
	cp_result_t        cp_expected_q[$];

	// floor of the square root, one result bit at a time from the top
	function automatic logic [BETA_W-1:0] root_floor(logic [63:0] x);
		logic [BETA_W-1:0] r;
		logic [BETA_W-1:0] t;
		r = '0;
		for (int i = BETA_W - 1; i >= 0; i--) begin
			t = r | (BETA_W'(1) << i);
			if (64'(t) * 64'(t) <= x) r = t;
		end
		return r;
	endfunction

	// beta and the factor come from the mach register seen at the first sample
	function automatic void derive_correction();
		logic [63:0] m2;
		m2 = 64'(mach_reg) * 64'(mach_reg);
		beta_q = root_floor((64'd1 << (2 * FRAC)) - m2);
		factor_q = BETA_W'((m2 >> 1) / ((64'd1 << FRAC) + 64'(beta_q)));
		derived = 1'b1;
	endfunction

	function automatic cp_result_t predict_coefficient(logic [SPEED_W-1:0] spd, logic lst);
		cp_result_t  res;
		logic [63:0] mag;
		logic [63:0] qd;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] p1;
		logic [63:0] p2;
		logic [63:0] diff;
		logic [127:0] den;
		logic [127:0] quo;
		logic        bad;
		logic        neg;
		if (!derived) derive_correction();
		mag = spd[SPEED_W-1] ? (64'd1 << SPEED_W) - 64'(spd) : 64'(spd);
		qd = (qinf_reg == '0) ? 64'd1 : 64'(qinf_reg);
		a = qd * qd;
		b = mag * mag;
		p1 = 64'(beta_q) * a;
		bad = 1'b0;
		neg = 1'b0;
		den = '0;
		if (a >= b) begin
			diff = a - b;
			p2 = 64'(factor_q) * diff;
			den = 128'(p1) + 128'(p2);
			bad = (den == '0);
		end else begin
			diff = b - a;
			p2 = 64'(factor_q) * diff;
			neg = 1'b1;
			if (p2 >= p1) bad = 1'b1;
			else den = 128'(p1 - p2);
		end
		res.pressure_coeff = CP_MIN;
		if (!bad) begin
			quo = (128'(diff) << (2 * FRAC)) / den;
			if (neg)
				res.pressure_coeff = (quo >= 128'(CP_MIN)) ? CP_MIN : -$signed(quo[CP_W-1:0]);
			else
				res.pressure_coeff = (quo > 128'(CP_MAX)) ? CP_MAX : quo[CP_W-1:0];
		end
		if (bad) sticky_bad = 1'b1;
		res.bad_denominator = bad;
		res.run_invalid = lst && sticky_bad;
		res.last_result = lst;
		if (lst) sticky_bad = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cp_result_t exp_res;
		if (!arst_n) begin
			qinf_reg = QINF_RESET;
			mach_reg = MACH_RESET;
			beta_q = '0;
			factor_q = '0;
			derived = 1'b0;
			sticky_bad = 1'b0;
			cp_expected_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FREESTREAM_SPEED: qinf_reg = wr_data[QINF_W-1:0];
					REG_FREESTREAM_MACH:  mach_reg = wr_data[MACH_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (cp_expected_q.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("unexpected result: cp %0d bad %0b run_invalid %0b last %0b",
							$signed(result.pressure_coeff), result.bad_denominator,
							result.run_invalid, result.last_result);
					errors++;
				end else begin
					exp_res = cp_expected_q.pop_front();
					if (exp_res.pressure_coeff !== result.pressure_coeff ||
						exp_res.bad_denominator !== result.bad_denominator ||
						exp_res.run_invalid !== result.run_invalid ||
						exp_res.last_result !== result.last_result) begin
						if (errors < REPORT_LIMIT)
							$display("mismatch: cp exp %0d got %0d, bad exp %0b got %0b, %s%0b got %0b, last exp %0b got %0b",
								$signed(exp_res.pressure_coeff), $signed(result.pressure_coeff),
								exp_res.bad_denominator, result.bad_denominator,
								"run_invalid exp ", exp_res.run_invalid, result.run_invalid,
								exp_res.last_result, result.last_result);
						errors++;
					end
				end
			end
			if (sample.valid && sample.ready)
				cp_expected_q.push_back(predict_coefficient(sample.surface_speed,
					sample.last_sample));
			pending <= cp_expected_q.size();
		end
	end

endmodule

// ===== dv/karman_tsien_pressure_coefficient_tb.sv =====
// karman_tsien_pressure_coefficient_tb: clock, reset, register writes, sample stimulus
// and result back-pressure for the pressure coefficient block; the checker module
// does all prediction and comparison, this top only drives and gives the verdict
module karman_tsien_pressure_coefficient_tb;
	import kt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either channel
	localparam int DRAIN_CYCLES   = 120;   // worst latency incl. the one-off derivation
	localparam int SETTLE_CYCLES  = 4;     // every sample yields a result, so little is needed
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 179;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	int               mismatches;
	int               outstanding;
	int               idle_cycles = 0;
	bit               src_calm;   // sender never idles in this phase
	bit               sink_calm;  // receiver never stalls in this phase
	logic [MACH_W-1:0] run_mach;
	logic [QINF_W-1:0] speed_setting;

	kt_sample_if sample_ch ();
	kt_result_if result_ch ();

	karman_tsien_pressure_coefficient dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	karman_tsien_pressure_coefficient_checker cp_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sample   (sample_ch),
		.result   (result_ch),
		.errors   (mismatches),
		.pending  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	// speeds spread over the full range, around the freestream speed, at the
	// extremes and near zero, so both signs of cpinc and bad denominators show up
	function automatic logic signed [SPEED_W-1:0] rand_speed(logic [QINF_W-1:0] q);
		int qd;
		int v;
		qd = (q == '0) ? 1 : int'(q);
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom_range(0, 262143) - 131072;
			3, 4, 5: begin
				v = $urandom_range(0, 2 * qd);
				if ($urandom_range(0, 1)) v = -v;
			end
			6: v = $urandom_range(0, 1) ? qd : -qd;
			7: begin
				case ($urandom_range(0, 4))
					0: v = 131071;
					1: v = -131072;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
			default: v = $urandom_range(0, 2048) - 1024;
		endcase
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return SPEED_W'(v);
	endfunction

	// one sample transfer; valid stays high into the next sample when there is no gap
	task automatic push_sample(input logic signed [SPEED_W-1:0] spd, input logic lst);
		int gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.surface_speed <= spd;
		sample_ch.last_sample <= lst;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// drop valid, then wait until every predicted result has come back
	task automatic settle(input int extra);
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	// registers are only written with the block idle
	task automatic set_registers(input logic [QINF_W-1:0] q, input bit with_mach,
		input logic [MACH_W-1:0] m);
		wr_en <= 1'b1;
		wr_index <= REG_FREESTREAM_SPEED;
		wr_data <= CFG_W'(q);
		@(posedge clk);
		if (with_mach) begin
			wr_index <= REG_FREESTREAM_MACH;
			wr_data <= CFG_W'(m);
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// receiver back-pressure
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap(sink_calm);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// watchdog: the run is stuck if neither channel transfers for too long
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int left;
		int run_len;
		bit cut;
		sample_ch.valid <= 1'b0;
		sample_ch.surface_speed <= '0;
		sample_ch.last_sample <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_FREESTREAM_SPEED;
		wr_data <= '0;
		arst_n <= 1'b0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mach only counts before the first sample, so it is chosen once per run;
		// high values are favored since they give bad denominators
		case ($urandom_range(0, 3))
			0: run_mach = 16'hFFFF;
			1: run_mach = MACH_W'($urandom_range(0, 65535));
			default: run_mach = MACH_W'($urandom_range(45000, 65534));
		endcase

		// directed: unit freestream speed, zero speed, equal speeds of both signs,
		// the extremes of the field, and a run end with and without a bad sample
		set_registers(QINF_RESET, 1'b1, run_mach);
		push_sample(0, 1'b0);
		push_sample(16384, 1'b0);
		push_sample(-16384, 1'b0);
		push_sample(131071, 1'b0);
		push_sample(-131072, 1'b0);
		push_sample(1, 1'b0);
		push_sample(-1, 1'b0);
		push_sample(32768, 1'b1);
		push_sample(8192, 1'b1);
		settle(SETTLE_CYCLES);

		// zero freestream speed acts as one lsb; mach rewritten after the first
		// sample must have no effect
		set_registers('0, 1'b1, '0);
		push_sample(0, 1'b0);
		push_sample(1, 1'b0);
		push_sample(-1, 1'b0);
		push_sample(131071, 1'b0);
		push_sample(-131072, 1'b1);
		settle(SETTLE_CYCLES);

		// largest freestream speed, mach at its top value (still ignored)
		set_registers(17'h1FFFF, 1'b1, 16'hFFFF);
		push_sample(131071, 1'b0);
		push_sample(-131072, 1'b0);
		push_sample(0, 1'b0);
		push_sample(65536, 1'b1);
		settle(SETTLE_CYCLES);

		set_registers(17'd1, 1'b0, '0);
		push_sample(0, 1'b0);
		push_sample(2, 1'b0);
		push_sample(-1, 1'b1);
		settle(SETTLE_CYCLES);

		// random: distributions of random length ending in a last sample, some cut
		// short so that a run spills into the next one
		for (int phase = 0; phase < PHASES; phase++) begin
			src_calm = (phase % 4 == 3);
			sink_calm = (phase % 4 == 1);
			case (phase)
				0: speed_setting = 17'd1;
				1: speed_setting = 17'h1FFFF;
				2: speed_setting = '0;
				default: speed_setting = $urandom_range(0, 1) ?
					QINF_W'($urandom_range(1, 131071)) :
					QINF_W'($urandom_range(8192, 32768));
			endcase
			set_registers(speed_setting, phase % 3 == 0, MACH_W'($urandom_range(0, 65535)));
			left = PHASE_ITEMS;
			while (left > 0) begin
				run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
				if (run_len > left) run_len = left;
				cut = ($urandom_range(0, 9) == 0);
				for (int i = 0; i < run_len; i++)
					push_sample(rand_speed(speed_setting), (i == run_len - 1) && !cut);
				left -= run_len;
			end
			settle(SETTLE_CYCLES);
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/kt_pkg.sv
rtl/core/kt_stream_if.sv
rtl/core/karman_tsien_pressure_coefficient.sv
dv/karman_tsien_pressure_coefficient_checker.sv
dv/karman_tsien_pressure_coefficient_tb.sv
